/* hw/rtl/dtm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtm_pkg
// Types and constants shared by the table-driven automaton matcher.
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int STATE_W    = 6;
  localparam int SYM_W      = 6;
  localparam int ADDR_W     = STATE_W + SYM_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int IN_WORD_W  = 32;
  localparam int OUT_WORD_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT     = 2'd2;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [STATE_W-1:0]   from_state;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   target_state;
    logic [IN_WORD_W-1:0] entry_word;
    logic                 first;
    logic                 last;
  } dtm_in_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] out_word;
    logic [STATE_W-1:0]    new_state;
    logic                  accepted;
    logic                  end_of_string;
  } dtm_out_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } dtm_wr_t;

  typedef enum logic {
    INIT_SWEEP,
    INIT_RUN
  } dtm_init_state_t;

endpackage

/* hw/rtl/dtm_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtm_table
// Transition table: next state and output word per (state, symbol) entry,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module dtm_table #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  dtm_pkg::dtm_wr_t             wr,
  input  logic [dtm_pkg::STATE_W-1:0]  wr_next,
  input  logic [WORD_WIDTH-1:0]        wr_word,
  input  logic                         rd_en,
  input  logic [dtm_pkg::ADDR_W-1:0]   rd_addr,
  output logic [dtm_pkg::STATE_W-1:0]  rd_next,
  output logic [WORD_WIDTH-1:0]        rd_word
);
  import dtm_pkg::*;

  logic [STATE_W-1:0]    next_mem [DEPTH];
  logic [WORD_WIDTH-1:0] word_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      next_mem[wr.addr] <= wr_next;
      word_mem[wr.addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_next <= next_mem[rd_addr];
      rd_word <= word_mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/dtm_init.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtm_init
// Clearing pass after reset: walks every table entry once, writing a
// self loop with a zero output word.
// ----------------------------------------------------------------------------
module dtm_init (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        sweeping,
  output dtm_pkg::dtm_wr_t            wr,
  output logic [dtm_pkg::STATE_W-1:0] wr_next
);
  import dtm_pkg::*;

  dtm_init_state_t   state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= INIT_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sweeping  = 1'b0;
    wr.en     = 1'b0;
    wr.addr   = cnt_r;
    case (state_r)
      INIT_SWEEP: begin
        sweeping = 1'b1;
        wr.en    = 1'b1;
        cnt_nxt  = cnt_r + ADDR_W'(1);
        if (&cnt_r) begin
          state_nxt = INIT_RUN;
        end
      end
      INIT_RUN: begin
        cnt_nxt = cnt_r;
      end
      default: begin
        state_nxt = INIT_SWEEP;
      end
    endcase
  end

  // row index is the self-loop target, row zero comes out zero
  assign wr_next = cnt_r[ADDR_W-1:SYM_W];

endmodule

/* hw/rtl/table_driven_dfa_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_dfa_matcher
// Table-driven deterministic automaton with Mealy outputs.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 4096 entries of the
// transition table (one entry a cycle) and holds in_stall high meanwhile;
// configuration writes are taken at any time. After that it takes one request
// per cycle unless a result is held by out_stall: table writes, symbol steps
// and empty-string queries. A request is registered in stage one, and a step's
// or query's result is registered into the output register as stage one advances.
// The rate is set by the state loop: the registered read of the table feeds the
// address of the next step directly, so steps can follow each other every cycle.
// ----------------------------------------------------------------------------
module table_driven_dfa_matcher #(
  parameter int MAX_STATES = 63,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dtm_pkg::dtm_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dtm_pkg::dtm_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtm_pkg::*;

  localparam logic [STATE_W-1:0] MAX_LIM = STATE_W'(MAX_STATES);

  // configuration
  logic [STATE_W-1:0]    num_states_r, start_state_r;
  logic [CFG_DATA_W-1:0] accept_mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= STATE_W'(1);
      start_state_r <= STATE_W'(1);
      accept_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_STATES: num_states_r  <= cfg_data[STATE_W-1:0];
        CFG_START:      start_state_r <= cfg_data[STATE_W-1:0];
        CFG_ACCEPT:     accept_mask_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // clearing pass
  logic               sweeping;
  dtm_wr_t            init_wr;
  logic [STATE_W-1:0] init_next;

  dtm_init u_init (
    .clk      (clk),
    .rst_n    (rst_n),
    .sweeping (sweeping),
    .wr       (init_wr),
    .wr_next  (init_next)
  );

  // pipeline control
  logic                  in_acc, out_vld_r, out_vld_nxt, out_free;
  logic                  s1_vld_r, s1_vld_nxt, s1_adv, s1_res;
  logic [1:0]            s1_req_r;
  logic                  s1_take_r, s1_last_r;
  logic [STATE_W-1:0]    s1_base_r, s1_after;
  logic [STATE_W-1:0]    cur_state_r, st_live, base;
  logic [STATE_W-1:0]    limit;
  logic                  take_in;
  logic                  rd_en;
  logic [STATE_W-1:0]    rd_next;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [63:0]           w64, r64;
  dtm_wr_t               tbl_wr;
  logic [STATE_W-1:0]    tbl_next;
  logic [WORD_WIDTH-1:0] tbl_word;
  dtm_out_t              res, out_data_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;
  assign s1_res   = (s1_req_r == REQ_STEP) || (s1_req_r == REQ_QUERY);
  assign s1_adv   = s1_vld_r && (!s1_res || out_free);
  assign in_stall = sweeping || (s1_vld_r && !s1_adv);

  // state after the request held in stage one, forwarded from the read port
  assign s1_after = ((s1_req_r == REQ_STEP) && s1_take_r) ? rd_next : s1_base_r;
  assign st_live  = s1_vld_r ? s1_after : cur_state_r;
  assign base     = ((in_data.req_type == REQ_STEP) && in_data.first) ? start_state_r
                                                                      : st_live;

  assign limit   = (num_states_r > MAX_LIM) ? MAX_LIM : num_states_r;
  assign take_in = (in_data.symbol != '0) && (in_data.symbol <= limit);

  assign rd_en = in_acc && (in_data.req_type == REQ_STEP);
  assign w64   = 64'(in_data.entry_word);
  assign r64   = 64'(rd_word);

  always_comb begin
    if (sweeping) begin
      tbl_wr   = init_wr;
      tbl_next = init_next;
      tbl_word = '0;
    end else begin
      tbl_wr.en   = in_acc && (in_data.req_type == REQ_WRITE);
      tbl_wr.addr = {in_data.from_state, in_data.symbol};
      tbl_next    = in_data.target_state;
      tbl_word    = w64[WORD_WIDTH-1:0];
    end
  end

  dtm_table #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .wr_next (tbl_next),
    .wr_word (tbl_word),
    .rd_en   (rd_en),
    .rd_addr ({base, in_data.symbol}),
    .rd_next (rd_next),
    .rd_word (rd_word)
  );

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv && s1_res) begin
      out_vld_nxt = 1'b1;
    end else if (out_free) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    if (s1_req_r == REQ_QUERY) begin
      res.out_word      = '0;
      res.new_state     = start_state_r;
      res.end_of_string = 1'b1;
    end else begin
      res.out_word      = s1_take_r ? r64[OUT_WORD_W-1:0] : '0;
      res.new_state     = s1_after;
      res.end_of_string = s1_last_r;
    end
    res.accepted = accept_mask_r[res.new_state];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      cur_state_r <= STATE_W'(1);
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      cur_state_r <= st_live;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_data.req_type;
      s1_take_r <= take_in;
      s1_base_r <= base;
      s1_last_r <= in_data.last;
    end
    if (s1_adv && s1_res) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // no result leaves while the table is still being cleared
  a_no_out_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !out_valid)
    else $error("result during clearing pass");

  // a held request keeps its table read data
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv && (s1_req_r == REQ_STEP)) |=> $stable(rd_next) && $stable(rd_word))
    else $error("read data lost while request held");

  // the reported state of a step is the state the next step starts from
  a_state_track: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_req_r == REQ_STEP)) |=> (out_data.new_state == cur_state_r))
    else $error("state register out of step with result");

endmodule

/* dv/tb_table_driven_dfa_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_driven_dfa_matcher
// Self-checking testbench for the table-driven automaton matcher.
// ----------------------------------------------------------------------------
// A directed table of requests runs against the reset settings first. Then
// eight phases each reprogram the registers, load a small transition table
// and feed strings with random symbols, mixed with random requests. An
// in-house automaton tracks the table, the current state and the registers
// and predicts every result. Results are compared field by field in order.
// The sender pauses in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_table_driven_dfa_matcher;
  import dtm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 185;

  typedef struct packed {
    logic     typed;
    dtm_out_t res;
  } typed_res_t;

  typedef struct packed {
    dtm_in_t  req;
    logic     typed;
    dtm_out_t res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  dtm_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  dtm_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // automaton mirror
  logic [STATE_W-1:0]    next_tbl [DEPTH];
  logic [IN_WORD_W-1:0]  word_tbl [DEPTH];
  logic [STATE_W-1:0]    cur_state;
  logic [STATE_W-1:0]    num_states_m;
  logic [STATE_W-1:0]    start_m;
  logic [63:0]           accept_m;

  typed_res_t            typed_q [$];
  dtm_out_t              expected_q [$];
  dir_row_t              dir_rows [$];

  int errors = 0;
  int checked = 0;
  int n_writes = 0;
  int n_steps = 0;
  int n_queries = 0;
  int n_ignored = 0;
  int sent = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;
  int stall_mode = 1;

  table_driven_dfa_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic run_automaton(input dtm_in_t rq, output dtm_out_t res);
    logic [ADDR_W-1:0] idx;
    res = '0;
    case (rq.req_type)
      REQ_WRITE: begin
        idx = {rq.from_state, rq.symbol};
        next_tbl[idx] = rq.target_state;
        word_tbl[idx] = rq.entry_word;
        return 1'b0;
      end
      REQ_STEP: begin
        if (rq.first) cur_state = start_m;
        if (rq.symbol != '0 && rq.symbol <= num_states_m) begin
          idx = {cur_state, rq.symbol};
          res.out_word = word_tbl[idx];
          cur_state = next_tbl[idx];
        end
        res.new_state = cur_state;
        res.accepted = accept_m[cur_state];
        res.end_of_string = rq.last;
        return 1'b1;
      end
      REQ_QUERY: begin
        res.new_state = start_m;
        res.accepted = accept_m[start_m];
        res.end_of_string = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 7) < 6) ? out_stall : !out_stall;
      endcase
    end
  end

  // result check, register and request tracking
  always @(posedge clk) begin : track
    dtm_out_t   exp_res;
    dtm_out_t   pred;
    typed_res_t tr;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: %h", $time, out_data);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          checked++;
          if (out_data.out_word !== exp_res.out_word) begin
            $display("%0t: out_word expected %h actual %h", $time,
                     exp_res.out_word, out_data.out_word);
            errors++;
          end
          if (out_data.new_state !== exp_res.new_state) begin
            $display("%0t: new_state expected %0d actual %0d", $time,
                     exp_res.new_state, out_data.new_state);
            errors++;
          end
          if (out_data.accepted !== exp_res.accepted) begin
            $display("%0t: accepted expected %b actual %b", $time,
                     exp_res.accepted, out_data.accepted);
            errors++;
          end
          if (out_data.end_of_string !== exp_res.end_of_string) begin
            $display("%0t: end_of_string expected %b actual %b", $time,
                     exp_res.end_of_string, out_data.end_of_string);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_STATES: num_states_m = cfg_data[STATE_W-1:0];
          CFG_START:      start_m = cfg_data[STATE_W-1:0];
          CFG_ACCEPT:     accept_m = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        tr = typed_q.pop_front();
        case (in_data.req_type)
          REQ_WRITE: n_writes++;
          REQ_STEP:  n_steps++;
          REQ_QUERY: n_queries++;
          default:   n_ignored++;
        endcase
        if (run_automaton(in_data, pred)) expected_q.push_back(tr.typed ? tr.res : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_req(input dtm_in_t rq, input logic typed, input dtm_out_t res);
    int gap;
    typed_q.push_back({typed, res});
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    if (burst_left != 0) burst_left--;
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic dir_add(input logic [1:0] rt, input logic [5:0] fr, input logic [5:0] sy,
                         input logic [5:0] tg, input logic [31:0] wd, input logic fi,
                         input logic la, input logic typed, input logic [31:0] ow,
                         input logic [5:0] ns, input logic ac, input logic eos);
    dir_row_t row;
    row.req = '{req_type: rt, from_state: fr, symbol: sy, target_state: tg,
                entry_word: wd, first: fi, last: la};
    row.typed = typed;
    row.res = '{out_word: ow, new_state: ns, accepted: ac, end_of_string: eos};
    dir_rows.push_back(row);
  endtask

  function automatic dtm_in_t random_req();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    return rnd[$bits(dtm_in_t)-1:0];
  endfunction

  initial begin
    int ph;
    int r;
    int c;
    int j;
    int len;
    int k_rows;
    int kk;
    int phase_end;
    dtm_in_t rq;
    logic [5:0] n_cfg;
    logic [5:0] s_cfg;
    logic [63:0] a_cfg;

    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_STATES;
    cfg_data = '0;
    for (r = 0; r < DEPTH; r++) begin
      next_tbl[r] = r[ADDR_W-1:SYM_W];
      word_tbl[r] = '0;
    end
    cur_state = 6'd1;
    num_states_m = 6'd1;
    start_m = 6'd1;
    accept_m = '0;

    // reset settings: one state, start in state one, nothing accepting
    dir_add(REQ_QUERY,  0,  0,  0, 32'h0,        0, 0, 1, 32'h0,        1, 0, 1);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        1, 0, 1, 32'h0,        1, 0, 0);
    dir_add(REQ_STEP,  63,  0, 63, 32'hffffffff, 0, 0, 1, 32'h0,        1, 0, 0);
    dir_add(REQ_STEP,   0, 63,  0, 32'h0,        0, 1, 1, 32'h0,        1, 0, 1);
    dir_add(REQ_UNUSED, 63, 63, 63, 32'hffffffff, 1, 1, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        1, 1, 1, 32'h0,        1, 0, 1);
    dir_add(REQ_WRITE,  1,  1,  0, 32'hffffffff, 0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        1, 0, 1, 32'hffffffff, 0, 0, 0);
    // row zero cleared by the sweep
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        0, 1, 1, 32'h0,        0, 0, 1);
    dir_add(REQ_WRITE,  0,  1, 63, 32'ha5a55a5a, 0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        0, 0, 1, 32'ha5a55a5a, 63, 0, 0);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        0, 1, 1, 32'h0,        63, 0, 1);
    dir_add(REQ_WRITE, 63, 63,  1, 32'h00000001, 0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,   0, 63,  0, 32'h0,        0, 0, 1, 32'h0,        63, 0, 0);
    dir_add(REQ_WRITE, 63,  1,  2, 32'h12345678, 0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_QUERY, 42, 21, 42, 32'hdeadbeef, 0, 0, 1, 32'h0,        1, 0, 1);
    dir_add(REQ_STEP,   0,  1,  0, 32'h0,        0, 1, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_WRITE,  0,  0,  0, 32'h0,        0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_WRITE,  2, 63, 63, 32'h80000000, 0, 0, 0, 32'h0,        0, 0, 0);
    dir_add(REQ_STEP,  21,  1, 21, 32'h0000ffff, 1, 1, 0, 32'h0,        0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin n_cfg = 6'd63; s_cfg = 6'd63; a_cfg = '1; end
        1: begin n_cfg = 6'd0;  s_cfg = 6'd0;  a_cfg = '0; end
        2: begin n_cfg = 6'd1;  s_cfg = 6'd0;  a_cfg = 64'h1; end
        6: begin
          n_cfg = 6'd63;
          s_cfg = 6'($urandom_range(0, 6));
          a_cfg = {$urandom, $urandom};
        end
        default: begin
          n_cfg = 6'($urandom_range(2, 8));
          s_cfg = 6'($urandom_range(0, n_cfg));
          a_cfg = {$urandom, $urandom};
        end
      endcase
      write_reg(CFG_NUM_STATES, {$urandom, 26'($urandom_range(0, 3)), n_cfg});
      write_reg(CFG_START, {$urandom, 26'($urandom_range(0, 3)), s_cfg});
      write_reg(CFG_ACCEPT, a_cfg);
      idle_on = (ph % 3 != 1);
      stall_mode = (ph == 4 || ph == 7) ? 0 : ph % 3;
      burst_left = 0;
      k_rows = (n_cfg > 6) ? 6 : n_cfg;
      kk = (k_rows == 0) ? 1 : k_rows;
      phase_end = sent + PHASE_ITEMS;

      // load a small machine over the low states
      for (r = 0; r <= k_rows; r++) begin
        for (c = 1; c <= k_rows; c++) begin
          rq = random_req();
          rq.req_type = REQ_WRITE;
          rq.from_state = STATE_W'(r);
          rq.symbol = SYM_W'(c);
          rq.target_state = STATE_W'($urandom_range(0, k_rows));
          send_req(rq, 1'b0, '0);
        end
      end

      while (sent < phase_end) begin
        if ($urandom_range(0, 99) < 15) begin
          send_req(random_req(), 1'b0, '0);
        end else if ($urandom_range(0, 99) < 4) begin
          rq = random_req();
          rq.req_type = REQ_QUERY;
          send_req(rq, 1'b0, '0);
        end else begin
          len = $urandom_range(1, 12);
          for (j = 0; j < len; j++) begin
            rq = random_req();
            rq.req_type = REQ_STEP;
            rq.symbol = ($urandom_range(0, 19) == 0) ? SYM_W'($urandom_range(0, 63))
                                                      : SYM_W'($urandom_range(1, kk));
            rq.first = (j == 0);
            rq.last = (j == len - 1);
            send_req(rq, 1'b0, '0);
          end
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d table writes, %0d symbol steps, %0d empty queries, %0d unused",
             n_writes, n_steps, n_queries, n_ignored);
    $display("checked %0d results over %0d register settings", checked, NUM_PHASES + 1);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
